// File: hdl/pcb_pkg.sv
// Shared types and constants of the PID biquad controller.
`timescale 1ns / 1ps
`default_nettype none

package pcb_pkg;

   localparam int DRIVE_WIDTH    = 24;
   localparam int COEF_WIDTH     = 24;
   localparam int LIMIT_WIDTH    = 23;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_ADDR_WIDTH = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_B0      = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_B1      = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_B2      = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_A1      = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_COEF_A2      = 3'd4;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_LIMIT        = 3'd5;
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_LIMIT_ENABLE = 3'd6;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = {LIMIT_WIDTH{1'b1}};

   typedef struct packed {
      logic [COEF_WIDTH-1:0]  coef_b0;
      logic [COEF_WIDTH-1:0]  coef_b1;
      logic [COEF_WIDTH-1:0]  coef_b2;
      logic [COEF_WIDTH-1:0]  coef_a1;
      logic [COEF_WIDTH-1:0]  coef_a2;
      logic [LIMIT_WIDTH-1:0] limit;
      logic                   limit_enable;
   } cfg_type;

endpackage

`default_nettype wire

// File: hdl/pid_biquad_controller.sv
// Top level of the PID biquad controller: word pipeline, history and checks.
//
// Fixed-point PID controller in biquad form. Each accepted word carries a
// setpoint, a measurement and a clear flag; the block returns one result word
// per input word with drive = (b0*e + b1*e1 + b2*e2 - a1*u1 - a2*u2) >> 16,
// clamped to +-limit when limit_enable is set and saturated to the 24-bit
// range otherwise, plus a flag that tells when bounding changed the value.
// A word with clear set zeroes the error and output history and returns 0.
// Throughput is one word per clock cycle while results are taken: the error,
// five multiplies, the sum and the bound run in one registered pass from the
// input register to the result register, and the bounded drive reaches the
// history in that same cycle. A word passes the input register and then the
// result register; a stalled result holds both registers, so req_ready drops
// once a second word waits. Coefficients are written through the csr_ port;
// the user must write them only while the block is idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module pid_biquad_controller
   import pcb_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16
)(
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input words
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_setpoint,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_measurement,
   input  wire logic                           req_clear,
   // result words
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [DRIVE_WIDTH-1:0]       rsp_drive,
   output logic                                rsp_clamped,
   // configuration writes
   input  wire logic                           csr_write_enable,
   input  wire logic [CSR_ADDR_WIDTH-1:0]      csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]      csr_data
);

   localparam int EW        = SAMPLE_WIDTH + 1;
   localparam int OPND_W    = (EW > DRIVE_WIDTH) ? EW : DRIVE_WIDTH;
   // widest product plus three bits of headroom for a five-term sum
   localparam int ACC_WIDTH = COEF_WIDTH + OPND_W + 3;

   cfg_type cfg;

   // Input register
   logic                    in_valid_ff;
   logic [SAMPLE_WIDTH-1:0] in_setpoint_ff;
   logic [SAMPLE_WIDTH-1:0] in_measurement_ff;
   logic                    in_clear_ff;

   // Result register
   logic                   rsp_valid_ff;
   logic [DRIVE_WIDTH-1:0] rsp_drive_ff;
   logic                   rsp_clamped_ff;

   // History
   logic [EW-1:0]          error_prev1_ff, error_prev2_ff;
   logic [DRIVE_WIDTH-1:0] output_prev1_ff, output_prev2_ff;

   logic                   req_accept;
   logic                   advance;
   logic [EW-1:0]          error;
   logic [ACC_WIDTH-1:0]   shifted;
   logic [DRIVE_WIDTH-1:0] bound_drive;
   logic                   bound_clamped;
   logic [DRIVE_WIDTH-1:0] rsp_drive_in;
   logic                   rsp_clamped_in;

   pcb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   // Advance the held word into the result register when that register is
   // empty or its word is taken this cycle; the input register refills in
   // the same cycle, so words stream at one per cycle while results are taken.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_setpoint_ff    <= req_setpoint;
         in_measurement_ff <= req_measurement;
         in_clear_ff       <= req_clear;
      end
   end

   pcb_filter #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .ACC_WIDTH      (ACC_WIDTH)
   ) u_filter (
      .setpoint     (in_setpoint_ff),
      .measurement  (in_measurement_ff),
      .error_prev1  (error_prev1_ff),
      .error_prev2  (error_prev2_ff),
      .output_prev1 (output_prev1_ff),
      .output_prev2 (output_prev2_ff),
      .cfg          (cfg),
      .error        (error),
      .shifted      (shifted)
   );

   pcb_bound #(
      .VALUE_WIDTH (ACC_WIDTH)
   ) u_bound (
      .value        (shifted),
      .limit        (cfg.limit),
      .limit_enable (cfg.limit_enable),
      .drive        (bound_drive),
      .clamped      (bound_clamped)
   );

   // A clear word answers zero and is never flagged.
   assign rsp_drive_in   = in_clear_ff ? '0 : bound_drive;
   assign rsp_clamped_in = in_clear_ff ? 1'b0 : bound_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_drive_ff   <= rsp_drive_in;
         rsp_clamped_ff <= rsp_clamped_in;
      end
   end

   // Shift the history once per processed word; clear zeroes all of it.
   always_ff @(posedge clock) begin
      if (reset) begin
         error_prev1_ff  <= '0;
         error_prev2_ff  <= '0;
         output_prev1_ff <= '0;
         output_prev2_ff <= '0;
      end else if (advance) begin
         if (in_clear_ff) begin
            error_prev1_ff  <= '0;
            error_prev2_ff  <= '0;
            output_prev1_ff <= '0;
            output_prev2_ff <= '0;
         end else begin
            error_prev1_ff  <= error;
            error_prev2_ff  <= error_prev1_ff;
            output_prev1_ff <= bound_drive;
            output_prev2_ff <= output_prev1_ff;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

   // A held input word is never lost while it waits for the result side.
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input word dropped while stalled");

   // A clear word leaves the whole history at zero.
   a_clear_history : assert property (@(posedge clock) disable iff (reset)
      advance && in_clear_ff |=> error_prev1_ff == '0 && error_prev2_ff == '0
                                 && output_prev1_ff == '0 && output_prev2_ff == '0)
      else $error("history not cleared");

   // The fed-back output is exactly the result word just produced.
   a_history_matches : assert property (@(posedge clock) disable iff (reset)
      advance |=> output_prev1_ff == rsp_drive_ff)
      else $error("history and result disagree");

   // With the clamp on, a flagged result sits exactly on one of the bounds.
   a_clamp_on_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clamped_ff && cfg.limit_enable |->
         rsp_drive_ff == {1'b0, cfg.limit} || rsp_drive_ff == -{1'b0, cfg.limit})
      else $error("clamped result off the limit");

endmodule

`default_nettype wire

// File: hdl/pcb_csr.sv
// Configuration register file of the PID biquad controller.
`timescale 1ns / 1ps
`default_nettype none

module pcb_csr
   import pcb_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_data,
   output cfg_type                        cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_b0      <= '0;
         cfg_ff.coef_b1      <= '0;
         cfg_ff.coef_b2      <= '0;
         cfg_ff.coef_a1      <= '0;
         cfg_ff.coef_a2      <= '0;
         cfg_ff.limit        <= LIMIT_RESET;
         cfg_ff.limit_enable <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_COEF_B0:      cfg_ff.coef_b0      <= csr_data[COEF_WIDTH-1:0];
            REG_COEF_B1:      cfg_ff.coef_b1      <= csr_data[COEF_WIDTH-1:0];
            REG_COEF_B2:      cfg_ff.coef_b2      <= csr_data[COEF_WIDTH-1:0];
            REG_COEF_A1:      cfg_ff.coef_a1      <= csr_data[COEF_WIDTH-1:0];
            REG_COEF_A2:      cfg_ff.coef_a2      <= csr_data[COEF_WIDTH-1:0];
            REG_LIMIT:        cfg_ff.limit        <= csr_data[LIMIT_WIDTH-1:0];
            REG_LIMIT_ENABLE: cfg_ff.limit_enable <= csr_data[0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hdl/pcb_filter.sv
// Error, five-tap multiply-accumulate and fraction shift of the controller.
`timescale 1ns / 1ps
`default_nettype none

module pcb_filter
   import pcb_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16,
   parameter int ACC_WIDTH      = 51
)(
   input  wire logic [SAMPLE_WIDTH-1:0] setpoint,
   input  wire logic [SAMPLE_WIDTH-1:0] measurement,
   input  wire logic [SAMPLE_WIDTH:0]   error_prev1,
   input  wire logic [SAMPLE_WIDTH:0]   error_prev2,
   input  wire logic [DRIVE_WIDTH-1:0]  output_prev1,
   input  wire logic [DRIVE_WIDTH-1:0]  output_prev2,
   input  cfg_type                      cfg,
   output logic [SAMPLE_WIDTH:0]        error,
   output logic [ACC_WIDTH-1:0]         shifted
);

   localparam int EW = SAMPLE_WIDTH + 1;

   logic signed [COEF_WIDTH-1:0]             c_b0, c_b1, c_b2, c_a1, c_a2;
   logic signed [EW-1:0]                     x_e0, x_e1, x_e2;
   logic signed [DRIVE_WIDTH-1:0]            x_u1, x_u2;
   logic signed [COEF_WIDTH+EW-1:0]          p_b0, p_b1, p_b2;
   logic signed [COEF_WIDTH+DRIVE_WIDTH-1:0] p_a1, p_a2;
   logic signed [ACC_WIDTH-1:0]              acc;

   // e = r - m, one bit wider than the samples so it never wraps
   assign error = {setpoint[SAMPLE_WIDTH-1], setpoint}
                - {measurement[SAMPLE_WIDTH-1], measurement};

   assign c_b0 = cfg.coef_b0;
   assign c_b1 = cfg.coef_b1;
   assign c_b2 = cfg.coef_b2;
   assign c_a1 = cfg.coef_a1;
   assign c_a2 = cfg.coef_a2;

   assign x_e0 = error;
   assign x_e1 = error_prev1;
   assign x_e2 = error_prev2;
   assign x_u1 = output_prev1;
   assign x_u2 = output_prev2;

   // Each product at its natural signed width.
   assign p_b0 = c_b0 * x_e0;
   assign p_b1 = c_b1 * x_e1;
   assign p_b2 = c_b2 * x_e2;
   assign p_a1 = c_a1 * x_u1;
   assign p_a2 = c_a2 * x_u2;

   // Full-width sum; the accumulator has headroom for all five products.
   assign acc = ACC_WIDTH'(p_b0) + ACC_WIDTH'(p_b1) + ACC_WIDTH'(p_b2)
              - ACC_WIDTH'(p_a1) - ACC_WIDTH'(p_a2);

   // Arithmetic shift rounds toward minus infinity.
   assign shifted = acc >>> COEF_FRAC_BITS;

endmodule

`default_nettype wire

// File: hdl/pcb_bound.sv
// Symmetric clamp or drive-range saturation of the controller output.
`timescale 1ns / 1ps
`default_nettype none

module pcb_bound
   import pcb_pkg::*;
#(
   parameter int VALUE_WIDTH = 51
)(
   input  wire logic [VALUE_WIDTH-1:0] value,
   input  wire logic [LIMIT_WIDTH-1:0] limit,
   input  wire logic                   limit_enable,
   output logic [DRIVE_WIDTH-1:0]      drive,
   output logic                        clamped
);

   logic signed [VALUE_WIDTH-1:0] v;
   logic signed [VALUE_WIDTH-1:0] hi;
   logic signed [VALUE_WIDTH-1:0] lo;
   logic signed [VALUE_WIDTH-1:0] lim_x;
   logic signed [VALUE_WIDTH-1:0] drive_max;

   assign v         = value;
   assign lim_x     = {{(VALUE_WIDTH-LIMIT_WIDTH){1'b0}}, limit};
   assign drive_max = {{(VALUE_WIDTH-DRIVE_WIDTH+1){1'b0}}, {(DRIVE_WIDTH-1){1'b1}}};
   assign hi        = limit_enable ? lim_x : drive_max;
   assign lo        = limit_enable ? -lim_x : ~drive_max;

   always_comb begin
      priority if (v > hi) begin
         drive   = hi[DRIVE_WIDTH-1:0];
         clamped = 1'b1;
      end else if (v < lo) begin
         drive   = lo[DRIVE_WIDTH-1:0];
         clamped = 1'b1;
      end else begin
         drive   = v[DRIVE_WIDTH-1:0];
         clamped = 1'b0;
      end
   end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench of the PID biquad controller: stimulus, drive prediction, result check.
`timescale 1ns / 1ps

module testbench;
   import pcb_pkg::*;

   localparam int SAMPLE_BITS     = 16;
   localparam int FRAC_BITS       = 16;
   localparam int HOLD_OFF_CYCLES = 80;   // long receiver hold-off that fills the block
   localparam int SETTLE_CYCLES   = 4;    // settle margin after the last result word
   localparam int WATCHDOG_LIMIT  = 500;  // cycles without any handshake or write
   localparam int PRINT_LIMIT     = 200;

   // The register file has seven entries; the last index decodes to nothing.
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [DRIVE_WIDTH-1:0] drive;
      logic                          clamped;
   } drive_word_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [SAMPLE_BITS-1:0]        req_setpoint;
   logic signed [SAMPLE_BITS-1:0]        req_measurement;
   logic                                 req_clear;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic signed [DRIVE_WIDTH-1:0]        rsp_drive;
   logic                                 rsp_clamped;
   logic                                 csr_write_enable;
   logic [CSR_ADDR_WIDTH-1:0]            csr_index;
   logic [CSR_DATA_WIDTH-1:0]            csr_data;

   // Predictor copy of the registers and of the filter history.
   cfg_type                              model_cfg;
   logic signed [SAMPLE_BITS:0]          err_hist1 = '0;
   logic signed [SAMPLE_BITS:0]          err_hist2 = '0;
   logic signed [DRIVE_WIDTH-1:0]        drive_hist1 = '0;
   logic signed [DRIVE_WIDTH-1:0]        drive_hist2 = '0;

   drive_word_type                       pending_drives[$];
   int                                   mismatch_count = 0;
   int                                   stall_cycles = 0;
   bit                                   sender_gaps = 1'b1;
   bit                                   receiver_gaps = 1'b1;
   bit                                   hold_off_request = 1'b0;

   pid_biquad_controller #(
      .SAMPLE_WIDTH   (SAMPLE_BITS),
      .COEF_FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_setpoint     (req_setpoint),
      .req_measurement  (req_measurement),
      .req_clear        (req_clear),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive        (rsp_drive),
      .rsp_clamped      (rsp_clamped),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   // Mirror a register write into the predictor; unknown indexes are ignored.
   function automatic void store_register(input logic [CSR_ADDR_WIDTH-1:0] idx,
                                          input logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         REG_COEF_B0:      model_cfg.coef_b0 = data[COEF_WIDTH-1:0];
         REG_COEF_B1:      model_cfg.coef_b1 = data[COEF_WIDTH-1:0];
         REG_COEF_B2:      model_cfg.coef_b2 = data[COEF_WIDTH-1:0];
         REG_COEF_A1:      model_cfg.coef_a1 = data[COEF_WIDTH-1:0];
         REG_COEF_A2:      model_cfg.coef_a2 = data[COEF_WIDTH-1:0];
         REG_LIMIT:        model_cfg.limit = data[LIMIT_WIDTH-1:0];
         REG_LIMIT_ENABLE: model_cfg.limit_enable = data[0];
         default: ;
      endcase
   endfunction

   // Compute the drive word for one accepted input word and advance the history.
   function automatic drive_word_type predict_drive(input logic signed [SAMPLE_BITS-1:0] sp,
                                                    input logic signed [SAMPLE_BITS-1:0] ms,
                                                    input logic clr);
      drive_word_type w;
      longint      e;
      longint      acc;
      longint      u;
      longint      hi;
      longint      lo;
      w.clamped = 1'b0;
      w.drive = '0;
      if (clr) begin
         // Clear wipes the whole history and answers zero.
         err_hist1 = '0;
         err_hist2 = '0;
         drive_hist1 = '0;
         drive_hist2 = '0;
         return w;
      end
      e = longint'(sp) - longint'(ms);
      // 24-bit coefficients times 17/24-bit history stay far inside 64 bits.
      acc = longint'($signed(model_cfg.coef_b0)) * e
          + longint'($signed(model_cfg.coef_b1)) * longint'(err_hist1)
          + longint'($signed(model_cfg.coef_b2)) * longint'(err_hist2)
          - longint'($signed(model_cfg.coef_a1)) * longint'(drive_hist1)
          - longint'($signed(model_cfg.coef_a2)) * longint'(drive_hist2);
      u = acc >>> FRAC_BITS;   // arithmetic shift rounds toward minus infinity
      if (model_cfg.limit_enable) begin
         hi = longint'(model_cfg.limit);
         lo = -hi;
      end else begin
         hi = (longint'(1) <<< (DRIVE_WIDTH - 1)) - 1;
         lo = -hi - 1;
      end
      // A value sitting exactly on a bound passes untouched.
      if (u > hi) begin
         u = hi;
         w.clamped = 1'b1;
      end else if (u < lo) begin
         u = lo;
         w.clamped = 1'b1;
      end
      drive_hist2 = drive_hist1;
      drive_hist1 = u[DRIVE_WIDTH-1:0];
      err_hist2 = err_hist1;
      err_hist1 = e[SAMPLE_BITS:0];
      w.drive = u[DRIVE_WIDTH-1:0];
      return w;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // Compare every accepted result word with the oldest predicted one.
   always @(posedge clock) begin : check_results
      drive_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drives.size() == 0) begin
            flag_mismatch($sformatf("result drive=%0d clamped=%0b with none pending",
                                    rsp_drive, rsp_clamped));
         end else begin
            want = pending_drives.pop_front();
            if (rsp_drive !== want.drive || rsp_clamped !== want.clamped)
               flag_mismatch($sformatf("drive=%0d clamped=%0b, predicted drive=%0d clamped=%0b",
                                       rsp_drive, rsp_clamped, want.drive, want.clamped));
         end
      end
   end

   // Abort when nothing moves for too long: no input word, result word or register write.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result side: random ready bursts, plus one long hold-off on request
   // ---------------------------------------------------------------------------------------

   initial begin : receiver
      int burst;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            // Hold ready low long enough for the block to back up into its input.
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            burst = $urandom_range(1, 13);
            repeat (burst) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input side. Every task starts and ends just after a falling edge.
   // ---------------------------------------------------------------------------------------

   // Offer one word and hold it until accepted. Valid stays high on exit so that a
   // following word goes out back to back; drain_results drops it.
   task automatic send_word(input logic signed [SAMPLE_BITS-1:0] sp,
                            input logic signed [SAMPLE_BITS-1:0] ms,
                            input logic clr);
      int gap;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 13);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_setpoint <= sp;
      req_measurement <= ms;
      req_clear <= clr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_drives.push_back(predict_drive(sp, ms, clr));
      @(negedge clock);
   endtask

   // Drop valid, wait for every predicted word to come back, then let the pipe settle.
   task automatic drain_results;
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write; enable is left high for a following write.
   task automatic write_register(input logic [CSR_ADDR_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      store_register(idx, data);
      @(negedge clock);
   endtask

   // Write the whole register set while the block is idle. The unused upper data bits
   // of the limit and enable registers and the dead index get random junk.
   task automatic apply_settings(input int b0, input int b1, input int b2,
                                 input int a1, input int a2, input int lim, input bit en);
      logic [CSR_DATA_WIDTH-1:0] junk;
      drain_results();
      junk = CSR_DATA_WIDTH'($urandom);
      write_register(REG_COEF_B0, b0[CSR_DATA_WIDTH-1:0]);
      write_register(REG_COEF_B1, b1[CSR_DATA_WIDTH-1:0]);
      write_register(REG_COEF_B2, b2[CSR_DATA_WIDTH-1:0]);
      write_register(REG_COEF_A1, a1[CSR_DATA_WIDTH-1:0]);
      write_register(REG_COEF_A2, a2[CSR_DATA_WIDTH-1:0]);
      write_register(REG_LIMIT, {junk[CSR_DATA_WIDTH-1], lim[LIMIT_WIDTH-1:0]});
      write_register(REG_LIMIT_ENABLE, {junk[CSR_DATA_WIDTH-1:1], en});
      write_register(REG_UNUSED, ~junk);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Either full-range coefficients, which mostly saturate, or a tame integrating
   // controller that keeps the drive inside its range for long stretches.
   task automatic random_settings(input bit tame);
      int lim;
      lim = $urandom_range(0, (1 << LIMIT_WIDTH) - 1);
      if (tame)
         apply_settings($urandom_range(0, 1 << 18), -int'($urandom_range(0, 1 << 18)),
                        int'($urandom_range(0, 1 << 16)) - (1 << 15),
                        -int'($urandom_range(1 << 15, 1 << 16)), $urandom_range(0, 1 << 14),
                        lim, 1'($urandom_range(0, 1)));
      else
         apply_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                        lim, 1'($urandom_range(0, 1)));
   endtask

   // Random word: full-range samples, or a measurement close to the setpoint.
   task automatic send_random_word;
      logic signed [SAMPLE_BITS-1:0] sp;
      logic signed [SAMPLE_BITS-1:0] ms;
      sp = SAMPLE_BITS'($urandom);
      if ($urandom_range(0, 2) == 0)
         ms = sp - SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
      else
         ms = SAMPLE_BITS'($urandom);
      send_word(sp, ms, $urandom_range(0, 19) == 0);
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // All coefficients come out of reset at zero: any error gives a zero drive.
   task automatic test_reset_state;
      send_word(16'sh7fff, -16'sh8000, 1'b0);
      send_word(-16'sh8000, 16'sh7fff, 1'b0);
   endtask

   task automatic test_directed_cases;
      // Unity proportional gain: drive follows the widest errors.
      apply_settings(1 << FRAC_BITS, 0, 0, 0, 0, (1 << LIMIT_WIDTH) - 1, 1'b0);
      send_word(16'sh7fff, -16'sh8000, 1'b0);
      send_word(-16'sh8000, 16'sh7fff, 1'b0);
      send_word(16'sh0000, 16'sh0000, 1'b0);
      // Smallest gain: a negative sum below one LSB rounds down to -1.
      apply_settings(1, 0, 0, 0, 0, (1 << LIMIT_WIDTH) - 1, 1'b0);
      send_word(16'sh0000, 16'sh0001, 1'b0);
      send_word(16'sh0001, 16'sh0000, 1'b0);
      // Extreme coefficients with positive feedback: saturate at both ends.
      apply_settings(8388607, -8388608, 8388607, -8388608, 8388607,
                     (1 << LIMIT_WIDTH) - 1, 1'b0);
      send_word(16'sh7fff, -16'sh8000, 1'b0);
      send_word(-16'sh8000, 16'sh7fff, 1'b0);
      send_word(16'sh7fff, -16'sh8000, 1'b0);
      send_word(-16'sh8000, 16'sh7fff, 1'b0);
      // Clear wipes the history; the next word sees no past.
      send_word(16'sh1234, -16'sh4321, 1'b1);
      send_word(16'sh0100, 16'sh0000, 1'b0);
      // Clamp at +-1000: on the bound is not clamped, one past it is.
      apply_settings(1 << FRAC_BITS, 0, 0, 0, 0, 1000, 1'b1);
      send_word(16'sd1000, 16'sd0, 1'b0);
      send_word(16'sd1001, 16'sd0, 1'b0);
      send_word(-16'sd1000, 16'sd0, 1'b0);
      send_word(-16'sd1001, 16'sd0, 1'b0);
      // Zero limit with clamp on: every drive is zero.
      apply_settings(8388607, 0, 0, 0, 0, 0, 1'b1);
      send_word(16'sh7fff, -16'sh8000, 1'b0);
      send_word(16'sh0000, 16'sh0000, 1'b0);
      // Widest limit with clamp on: the low bound is -limit, not the range minimum.
      apply_settings(8388607, -8388608, 8388607, -8388608, 8388607,
                     (1 << LIMIT_WIDTH) - 1, 1'b1);
      send_word(-16'sh8000, 16'sh7fff, 1'b0);
      send_word(16'sh7fff, -16'sh8000, 1'b0);
   endtask

   // Stall the result side for a long stretch while words keep coming, so the block
   // fills up and has to drop req_ready.
   task automatic test_backpressure;
      random_settings(1'b1);
      sender_gaps = 1'b0;
      hold_off_request = 1'b1;
      repeat (30) send_random_word();
      sender_gaps = 1'b1;
      drain_results();
   endtask

   // Several register settings, each with its own idling pattern.
   task automatic test_random_phases;
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         random_settings(phase % 3 != 2);
         sender_gaps = $urandom_range(0, 3) != 0;
         receiver_gaps = $urandom_range(0, 3) != 0;
         repeat (40) send_random_word();
      end
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_quiet_tail;
      random_settings(1'b1);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      repeat (40) send_random_word();
   endtask

   initial begin : run
      // Predictor registers start at their reset values.
      model_cfg = '0;
      model_cfg.limit = LIMIT_RESET;
      reset = 1'b1;
      req_valid = 1'b0;
      req_setpoint = '0;
      req_measurement = '0;
      req_clear = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_COEF_B0;
      csr_data = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_directed_cases();
      test_backpressure();
      test_random_phases();
      test_quiet_tail();

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
hdl/pcb_pkg.sv
hdl/pcb_csr.sv
hdl/pcb_filter.sv
hdl/pcb_bound.sv
hdl/pid_biquad_controller.sv
verif/testbench.sv
